// ===== rtl/lst_pkg.sv =====
// lst_pkg: shared widths and constants for the lap sector split timer
// used by the channel interfaces and the top level; no dependencies
`default_nettype none

package lst_pkg;

  localparam int NumSectorsDefault = 3;

  localparam int LapW = 32;
  localparam int MsW = 32;
  localparam int DurW = 31;
  localparam int PosW = 23;
  localparam int SecNumW = 2;

  // lap position scales in Q7.16
  localparam int ProdW = 27;
  localparam logic [ProdW-1:0] OneQ16 = 27'd65536;
  localparam logic [ProdW-1:0] PercentQ16 = 27'd6553600;

  localparam logic signed [LapW-1:0] NoLap = -32'sd1;

endpackage

`default_nettype wire

// ===== rtl/lst_frame_if.sv =====
// lst_frame_if: valid/ready channel carrying one telemetry frame word
// depends on lst_pkg for field widths
`default_nettype none

interface lst_frame_if;
  logic valid;
  logic ready;
  logic new_session;
  logic signed [lst_pkg::LapW-1:0] lap_no;
  logic signed [lst_pkg::MsW-1:0] lap_elapsed_ms;
  logic signed [lst_pkg::MsW-1:0] last_lap_ms;
  logic position_present;
  logic [lst_pkg::PosW-1:0] track_pos;

  modport source (
    output valid, new_session, lap_no, lap_elapsed_ms, last_lap_ms,
           position_present, track_pos,
    input  ready
  );

  modport sink (
    input  valid, new_session, lap_no, lap_elapsed_ms, last_lap_ms,
           position_present, track_pos,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/lst_result_if.sv =====
// lst_result_if: valid/ready channel carrying one sector timing result word
// depends on lst_pkg for field widths
`default_nettype none

interface lst_result_if;
  logic valid;
  logic ready;
  logic final_sector_valid;
  logic [lst_pkg::DurW-1:0] final_sector_ms;
  logic signed [lst_pkg::MsW-1:0] final_sector_delta_ms;
  logic split_sector_valid;
  logic [lst_pkg::SecNumW-1:0] split_sector_number;
  logic [lst_pkg::DurW-1:0] split_sector_ms;
  logic signed [lst_pkg::MsW-1:0] split_sector_delta_ms;
  logic best_lap_valid;
  logic [lst_pkg::DurW-1:0] fastest_lap_ms;

  modport source (
    output valid, final_sector_valid, final_sector_ms, final_sector_delta_ms,
           split_sector_valid, split_sector_number, split_sector_ms,
           split_sector_delta_ms, best_lap_valid, fastest_lap_ms,
    input  ready
  );

  modport sink (
    input  valid, final_sector_valid, final_sector_ms, final_sector_delta_ms,
           split_sector_valid, split_sector_number, split_sector_ms,
           split_sector_delta_ms, best_lap_valid, fastest_lap_ms,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/lap_sector_split_timer.sv =====
// lap_sector_split_timer: an accepted frame goes into the input register, then one pass of
// compare/subtract logic writes its timing word into the result register
// throughput one frame per cycle; a held frame waits only while the result is not taken
// rst (synchronous, active high) clears pipeline valids, tracked lap to -1,
// split count, sector bests and best lap; split times are not cleared
// depends on lst_pkg, lst_frame_if, lst_result_if
`default_nettype none

module lap_sector_split_timer #(
  parameter int NUM_SECTORS = lst_pkg::NumSectorsDefault
) (
  input  wire logic    clk,
  input  wire logic    rst,
  lst_frame_if.sink    in,
  lst_result_if.source out
);

  localparam int CntW = $clog2(NUM_SECTORS);
  localparam int SplitDepth = NUM_SECTORS - 1;
  localparam int SplitW = (SplitDepth > 1) ? $clog2(SplitDepth) : 1;
  localparam int LastSplit = NUM_SECTORS - 2;
  localparam int LastSector = NUM_SECTORS - 1;
  localparam int DurW = lst_pkg::DurW;
  localparam int ProdW = lst_pkg::ProdW;

  typedef struct packed {
    logic new_session;
    logic signed [lst_pkg::LapW-1:0] lap_no;
    logic signed [lst_pkg::MsW-1:0] lap_elapsed_ms;
    logic signed [lst_pkg::MsW-1:0] last_lap_ms;
    logic position_present;
    logic [lst_pkg::PosW-1:0] track_pos;
  } frame_t;

  // input stage
  logic   s1_valid;
  frame_t s1;

  // block state
  logic signed [lst_pkg::LapW-1:0] tracked_lap;
  logic [CntW-1:0] split_count;
  logic [DurW-1:0] split_times [SplitDepth];
  logic [DurW-1:0] best_sector [NUM_SECTORS];
  logic [DurW-1:0] best_lap;

  logic out_free;
  logic fire;

  assign out_free = !out.valid || out.ready;
  assign fire = s1_valid && out_free;
  assign in.ready = !s1_valid || out_free;

  // combinational pass
  logic signed [lst_pkg::LapW-1:0] eff_tracked;
  logic [CntW-1:0] eff_count;
  logic [DurW-1:0] eff_best_sector [NUM_SECTORS];
  logic [DurW-1:0] eff_best_lap;
  logic lap_change;
  logic done_pos;
  logic close_lap;
  logic [32:0] fin_dur;
  logic fin_rec;
  logic [DurW-1:0] fin_best;
  logic [lst_pkg::MsW-1:0] fin_delta;
  logic [DurW-1:0] best_lap_next;
  logic [CntW-1:0] count2;
  logic [CntW+1:0] k;
  logic [ProdW-1:0] scale;
  logic [ProdW-1:0] lhs;
  logic [ProdW-1:0] rhs;
  logic [DurW-1:0] prev;
  logic [32:0] spl_dur;
  logic spl_rec;
  logic [DurW-1:0] spl_best;
  logic [lst_pkg::MsW-1:0] spl_delta;
  logic [DurW-1:0] best_sector_next [NUM_SECTORS];
  logic [CntW-1:0] split_count_next;

  always_comb begin
    eff_tracked = s1.new_session ? lst_pkg::NoLap : tracked_lap;
    eff_count = s1.new_session ? '0 : split_count;
    eff_best_lap = s1.new_session ? '0 : best_lap;
    for (int i = 0; i < NUM_SECTORS; i++) begin
      eff_best_sector[i] = s1.new_session ? '0 : best_sector[i];
    end

    lap_change = s1.lap_no != eff_tracked;
    done_pos = !s1.last_lap_ms[31] && (s1.last_lap_ms != '0);
    close_lap = lap_change && !eff_tracked[31] && done_pos;

    // last sector closes only when every split of the lap was taken
    fin_dur = {s1.last_lap_ms[31], s1.last_lap_ms}
            - {2'b00, split_times[LastSplit]};
    fin_best = eff_best_sector[LastSector];
    fin_rec = close_lap && (eff_count == CntW'(LastSector))
            && !fin_dur[32] && (fin_dur != '0);
    fin_delta = (fin_best == '0) ? '0 : ({1'b0, fin_dur[DurW-1:0]} - {1'b0, fin_best});

    if (eff_best_lap == '0 || s1.last_lap_ms[DurW-1:0] < eff_best_lap) begin
      best_lap_next = s1.last_lap_ms[DurW-1:0];
    end else begin
      best_lap_next = eff_best_lap;
    end

    count2 = lap_change ? '0 : eff_count;
    k = (CntW+2)'(count2) + (CntW+2)'(1);
    scale = (ProdW'(s1.track_pos) > lst_pkg::OneQ16) ? lst_pkg::PercentQ16 : lst_pkg::OneQ16;
    lhs = ProdW'(s1.track_pos) * ProdW'(NUM_SECTORS);
    rhs = ProdW'(k) * scale;
    prev = (count2 != '0) ? split_times[SplitW'(count2 - CntW'(1))] : '0;
    spl_dur = {s1.lap_elapsed_ms[31], s1.lap_elapsed_ms} - {2'b00, prev};
    spl_best = eff_best_sector[count2];
    spl_rec = s1.position_present && (count2 < CntW'(LastSector)) && (lhs >= rhs)
            && !spl_dur[32] && (spl_dur != '0);
    spl_delta = (spl_best == '0) ? '0 : ({1'b0, spl_dur[DurW-1:0]} - {1'b0, spl_best});

    // split and final sector never touch the same best entry
    for (int i = 0; i < NUM_SECTORS; i++) begin
      best_sector_next[i] = eff_best_sector[i];
    end
    if (fin_rec && (fin_best == '0 || fin_dur[DurW-1:0] < fin_best)) begin
      best_sector_next[LastSector] = fin_dur[DurW-1:0];
    end
    if (spl_rec && (spl_best == '0 || spl_dur[DurW-1:0] < spl_best)) begin
      best_sector_next[count2] = spl_dur[DurW-1:0];
    end

    split_count_next = spl_rec ? CntW'(k) : count2;
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in.ready) begin
      s1_valid <= in.valid;
    end
    if (in.valid && in.ready) begin
      s1.new_session <= in.new_session;
      s1.lap_no <= in.lap_no;
      s1.lap_elapsed_ms <= in.lap_elapsed_ms;
      s1.last_lap_ms <= in.last_lap_ms;
      s1.position_present <= in.position_present;
      s1.track_pos <= in.track_pos;
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      tracked_lap <= lst_pkg::NoLap;
      split_count <= '0;
      best_lap <= '0;
      for (int i = 0; i < NUM_SECTORS; i++) begin
        best_sector[i] <= '0;
      end
    end else if (fire) begin
      tracked_lap <= s1.lap_no;
      split_count <= split_count_next;
      best_lap <= close_lap ? best_lap_next : eff_best_lap;
      for (int i = 0; i < NUM_SECTORS; i++) begin
        best_sector[i] <= best_sector_next[i];
      end
    end
    if (fire && spl_rec) begin
      split_times[SplitW'(count2)] <= s1.lap_elapsed_ms[DurW-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (out_free) begin
      out.valid <= s1_valid;
    end
    if (fire) begin
      out.final_sector_valid <= fin_rec;
      out.final_sector_ms <= fin_rec ? fin_dur[DurW-1:0] : '0;
      out.final_sector_delta_ms <= fin_rec ? fin_delta : '0;
      out.split_sector_valid <= spl_rec;
      out.split_sector_number <= spl_rec ? k[1:0] : '0;
      out.split_sector_ms <= spl_rec ? spl_dur[DurW-1:0] : '0;
      out.split_sector_delta_ms <= spl_rec ? spl_delta : '0;
      out.best_lap_valid <= close_lap;
      out.fastest_lap_ms <= close_lap ? best_lap_next : '0;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    split_count <= CntW'(LastSector))
    else $error("split count beyond last split");

  a_final_implies_lap: assert property (@(posedge clk) disable iff (rst)
    out.valid && out.final_sector_valid |-> out.best_lap_valid)
    else $error("final sector without lap close");

  a_split_nonzero: assert property (@(posedge clk) disable iff (rst)
    out.valid && out.split_sector_valid |->
      (out.split_sector_ms != '0) && (out.split_sector_number != '0))
    else $error("split recorded with zero time or number");

  a_best_lap_nonzero: assert property (@(posedge clk) disable iff (rst)
    out.valid && out.best_lap_valid |-> out.fastest_lap_ms != '0)
    else $error("best lap reported as zero");

  a_split_advances: assert property (@(posedge clk) disable iff (rst)
    fire && spl_rec |=> split_count == $past(CntW'(k)))
    else $error("split count did not advance");
`endif

endmodule

`default_nettype wire

// ===== tb/lap_sector_split_timer_tb.sv =====
// lap_sector_split_timer_tb: self-checking bench for the lap sector split timer
// drives telemetry frame words and checks every timing result word against a predictor
// depends on lst_pkg, lst_frame_if, lst_result_if and the lap_sector_split_timer top
`timescale 1ns / 100ps

module lap_sector_split_timer_tb;

  localparam int NumSectors = lst_pkg::NumSectorsDefault;
  localparam int LapW = lst_pkg::LapW;
  localparam int MsW = lst_pkg::MsW;
  localparam int DurW = lst_pkg::DurW;
  localparam int PosW = lst_pkg::PosW;
  localparam int SecNumW = lst_pkg::SecNumW;
  localparam int StallLimit = 2000;
  localparam int PhaseItems = 550;

  typedef struct packed {
    logic new_session;
    logic signed [LapW-1:0] lap_no;
    logic signed [MsW-1:0] lap_elapsed_ms;
    logic signed [MsW-1:0] last_lap_ms;
    logic position_present;
    logic [PosW-1:0] track_pos;
  } frame_t;

  typedef struct packed {
    logic final_valid;
    logic [DurW-1:0] final_ms;
    logic signed [MsW-1:0] final_delta;
    logic split_valid;
    logic [SecNumW-1:0] split_num;
    logic [DurW-1:0] split_ms;
    logic signed [MsW-1:0] split_delta;
    logic best_valid;
    logic [DurW-1:0] best_ms;
  } timing_t;

  // mirrors the lap and sector bests and queues the timing word each frame should give
  class sector_timing_board;
    logic signed [LapW-1:0] tracked_lap;
    int split_count;
    longint split_times[NumSectors-1];
    longint best_sector[NumSectors];
    longint best_lap;
    timing_t timing_q[$];
    int errors = 0;
    int n_frames = 0;
    int n_results = 0;
    int n_split = 0;
    int n_final = 0;
    int n_best = 0;

    function void clear_session();
      tracked_lap = lst_pkg::NoLap;
      split_count = 0;
      foreach (best_sector[i]) best_sector[i] = 0;
      best_lap = 0;
    endfunction

    function int pending();
      return timing_q.size();
    endfunction

    // a zero best means no best yet
    function bit take_sector(int idx, longint dur, output longint delta);
      longint best;
      delta = 0;
      if (dur <= 0) return 1'b0;
      best = best_sector[idx];
      delta = (best != 0) ? dur - best : 0;
      if (best == 0 || dur < best) best_sector[idx] = dur;
      return 1'b1;
    endfunction

    function void note_frame(frame_t f);
      timing_t r;
      longint dur;
      longint delta;
      longint prev;
      longint k;
      longint scale;
      r = '0;
      n_frames++;
      if (f.new_session) clear_session();
      if (f.lap_no != tracked_lap) begin
        if (tracked_lap >= 0 && f.last_lap_ms > 0) begin
          if (split_count == NumSectors - 1) begin
            dur = longint'(f.last_lap_ms) - split_times[NumSectors-2];
            if (take_sector(NumSectors - 1, dur, delta)) begin
              r.final_valid = 1'b1;
              r.final_ms = dur[DurW-1:0];
              r.final_delta = delta[MsW-1:0];
            end
          end
          if (best_lap == 0 || longint'(f.last_lap_ms) < best_lap)
            best_lap = longint'(f.last_lap_ms);
          r.best_valid = 1'b1;
          r.best_ms = best_lap[DurW-1:0];
        end
        tracked_lap = f.lap_no;
        split_count = 0;
      end
      if (f.position_present && split_count < NumSectors - 1) begin
        k = split_count + 1;
        // above 1.0 the position is a percent
        scale = (f.track_pos > lst_pkg::OneQ16) ? longint'(lst_pkg::PercentQ16)
                                                : longint'(lst_pkg::OneQ16);
        if (longint'(f.track_pos) * NumSectors >= k * scale) begin
          prev = (split_count != 0) ? split_times[split_count-1] : 0;
          dur = longint'(f.lap_elapsed_ms) - prev;
          if (take_sector(split_count, dur, delta)) begin
            r.split_valid = 1'b1;
            r.split_num = k[SecNumW-1:0];
            r.split_ms = dur[DurW-1:0];
            r.split_delta = delta[MsW-1:0];
            split_times[split_count] = longint'(f.lap_elapsed_ms);
            split_count++;
          end
        end
      end
      timing_q.insert(timing_q.size(), r);
    endfunction

    function void compare_field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
      end
    endfunction

    function void check_result(timing_t got);
      timing_t want;
      n_results++;
      if (got.split_valid) n_split++;
      if (got.final_valid) n_final++;
      if (got.best_valid) n_best++;
      if (timing_q.size() == 0) begin
        errors++;
        $display("%0t: result word with no frame waiting, actual %0h", $time, got);
        return;
      end
      want = timing_q[0];
      timing_q.delete(0);
      compare_field("final_sector_valid", 32'(want.final_valid), 32'(got.final_valid));
      compare_field("final_sector_ms", 32'(want.final_ms), 32'(got.final_ms));
      compare_field("final_sector_delta_ms", 32'(want.final_delta), 32'(got.final_delta));
      compare_field("split_sector_valid", 32'(want.split_valid), 32'(got.split_valid));
      compare_field("split_sector_number", 32'(want.split_num), 32'(got.split_num));
      compare_field("split_sector_ms", 32'(want.split_ms), 32'(got.split_ms));
      compare_field("split_sector_delta_ms", 32'(want.split_delta), 32'(got.split_delta));
      compare_field("best_lap_valid", 32'(want.best_valid), 32'(got.best_valid));
      compare_field("fastest_lap_ms", 32'(want.best_ms), 32'(got.best_ms));
    endfunction
  endclass

  logic clk;
  logic rst;
  int src_idle;
  int snk_idle;
  int stall_cycles;
  sector_timing_board board;

  // well-formed lap generator state
  int g_lap;
  int g_ms;
  int g_pos;
  int g_done;
  bit g_pct;

  lst_frame_if frame_ch ();
  lst_result_if timing_ch ();

  lap_sector_split_timer dut (
    .clk(clk),
    .rst(rst),
    .in(frame_ch),
    .out(timing_ch)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    timing_ch.ready <= ($urandom_range(0, 99) >= snk_idle);
  end

  always @(posedge clk) begin
    timing_t got;
    frame_t f;
    if (!rst) begin
      if (timing_ch.valid && timing_ch.ready) begin
        got.final_valid = timing_ch.final_sector_valid;
        got.final_ms = timing_ch.final_sector_ms;
        got.final_delta = timing_ch.final_sector_delta_ms;
        got.split_valid = timing_ch.split_sector_valid;
        got.split_num = timing_ch.split_sector_number;
        got.split_ms = timing_ch.split_sector_ms;
        got.split_delta = timing_ch.split_sector_delta_ms;
        got.best_valid = timing_ch.best_lap_valid;
        got.best_ms = timing_ch.fastest_lap_ms;
        board.check_result(got);
      end
      if (frame_ch.valid && frame_ch.ready) begin
        f.new_session = frame_ch.new_session;
        f.lap_no = frame_ch.lap_no;
        f.lap_elapsed_ms = frame_ch.lap_elapsed_ms;
        f.last_lap_ms = frame_ch.last_lap_ms;
        f.position_present = frame_ch.position_present;
        f.track_pos = frame_ch.track_pos;
        board.note_frame(f);
      end
    end
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if (rst || (frame_ch.valid && frame_ch.ready) || (timing_ch.valid && timing_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= StallLimit) begin
      $display("timeout after %0d idle cycles at %0t", StallLimit, $time);
      $display("FAIL lap_sector_split_timer");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic frame_t make_frame(bit ns, int lap, int cur, int done, bit pp, int pos);
    frame_t f;
    f.new_session = ns;
    f.lap_no = lap;
    f.lap_elapsed_ms = cur;
    f.last_lap_ms = done;
    f.position_present = pp;
    f.track_pos = pos[PosW-1:0];
    return f;
  endfunction

  // called just after a falling edge, returns just after a falling edge
  task automatic send_frame(input frame_t f);
    while ($urandom_range(0, 99) < src_idle) begin
      frame_ch.valid <= 1'b0;
      @(negedge clk);
    end
    frame_ch.valid <= 1'b1;
    frame_ch.new_session <= f.new_session;
    frame_ch.lap_no <= f.lap_no;
    frame_ch.lap_elapsed_ms <= f.lap_elapsed_ms;
    frame_ch.last_lap_ms <= f.last_lap_ms;
    frame_ch.position_present <= f.position_present;
    frame_ch.track_pos <= f.track_pos;
    @(posedge clk);
    while (!frame_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    frame_ch.valid <= 1'b0;
    do @(negedge clk); while (board.pending() != 0);
  endtask

  // mostly laps with rising time and position, some noise frames and session restarts
  task automatic plan_frame(output frame_t f);
    int r;
    r = $urandom_range(0, 99);
    f = '0;
    if (r < 12) begin
      f.new_session = ($urandom_range(0, 19) == 0);
      f.lap_no = ($urandom_range(0, 3) == 0) ? -1 : 32'($urandom() >> 1);
      f.lap_elapsed_ms = $urandom();
      f.last_lap_ms = $urandom();
      f.position_present = 1'($urandom_range(0, 1));
      f.track_pos = PosW'($urandom_range(0, 6553600));
      return;
    end
    if (r < 14) begin
      f.new_session = 1'b1;
      g_lap = $urandom_range(0, 5);
      g_ms = 0;
      g_pos = 0;
      g_done = 0;
      g_pct = 1'($urandom_range(0, 1));
    end else if (g_pos >= 65536 || r < 16) begin
      g_done = ($urandom_range(0, 9) == 0) ? -int'($urandom_range(0, 1000)) : g_ms;
      g_lap = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 100) : g_lap + 1;
      g_ms = $urandom_range(0, 400);
      g_pos = $urandom_range(0, 3000);
      g_pct = 1'($urandom_range(0, 1));
    end else begin
      g_ms += $urandom_range(0, 2500);
      if ($urandom_range(0, 29) == 0) g_ms -= $urandom_range(0, 3000);
      g_pos += $urandom_range(0, 10000);
      if (g_pos > 65536) g_pos = 65536;
    end
    f.lap_no = g_lap;
    f.lap_elapsed_ms = g_ms;
    f.last_lap_ms = g_done;
    f.position_present = ($urandom_range(0, 9) != 0);
    f.track_pos = PosW'(g_pct ? g_pos * 100 : g_pos);
  endtask

  initial begin
    frame_t f;
    frame_t directed[$];
    clk = 1'b0;
    rst = 1'b1;
    src_idle = 7;
    snk_idle = 49;
    stall_cycles = 0;
    frame_ch.valid = 1'b0;
    frame_ch.new_session = 1'b0;
    frame_ch.lap_no = '0;
    frame_ch.lap_elapsed_ms = '0;
    frame_ch.last_lap_ms = '0;
    frame_ch.position_present = 1'b0;
    frame_ch.track_pos = '0;
    timing_ch.ready = 1'b0;
    g_lap = 0;
    g_ms = 0;
    g_pos = 0;
    g_done = 0;
    g_pct = 1'b0;
    board = new;
    board.clear_session();

    // first third just short of and just at the boundary, then the same for the second third
    directed.insert(directed.size(), make_frame(1, -1, 0, 0, 0, 0));
    directed.insert(directed.size(), make_frame(0, 0, 100, 0, 1, 21845));
    directed.insert(directed.size(), make_frame(0, 0, 1000, 0, 1, 21846));
    directed.insert(directed.size(), make_frame(0, 0, 1500, 0, 1, 43690));
    directed.insert(directed.size(), make_frame(0, 0, 2000, 0, 1, 43691));
    // lap change closing the last sector and taking sector one in the same frame
    directed.insert(directed.size(), make_frame(0, 1, 400, 3000, 1, 21846));
    directed.insert(directed.size(), make_frame(0, 1, 32'h7fffffff, 3000, 1, 65536));
    // last sector of zero length, percent just short of a third
    directed.insert(directed.size(),
                    make_frame(0, 2, 32'h80000000, 32'h7fffffff, 1, 2184533));
    directed.insert(directed.size(), make_frame(0, 2, 50, 0, 1, 2184534));
    directed.insert(directed.size(), make_frame(0, 2, 60, 0, 1, 6553600));
    // no completed lap, then crossings with nonpositive durations
    directed.insert(directed.size(), make_frame(0, 3, 10, 32'h80000000, 0, 0));
    directed.insert(directed.size(), make_frame(0, 3, -5, 0, 1, 65537));
    directed.insert(directed.size(), make_frame(0, 3, -5, 0, 1, 6553600));
    directed.insert(directed.size(), make_frame(0, 3, 0, 0, 1, 6553600));
    directed.insert(directed.size(), make_frame(0, 32'h7fffffff, 70, 0, 1, 6553600));
    directed.insert(directed.size(), make_frame(1, 32'h7fffffff, 80, 5000, 1, 0));
    directed.insert(directed.size(), make_frame(0, -1, 90, 100, 0, 65536));
    directed.insert(directed.size(), make_frame(0, -1, 123, 100, 1, 65536));
    directed.insert(directed.size(),
                    make_frame(0, -1, 32'h55555555, 32'haaaaaaaa, 1, 23'h2aaaaa));
    directed.insert(directed.size(),
                    make_frame(0, 5, 32'haaaaaaaa, 32'h55555555, 1, 23'h155555));

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_frame(directed[i]);

    for (int phase = 0; phase < 3; phase++) begin
      src_idle = (phase == 0) ? 7 : (phase == 1) ? 49 : 0;
      snk_idle = (phase == 0) ? 49 : (phase == 1) ? 7 : 0;
      for (int i = 0; i < PhaseItems; i++) begin
        plan_frame(f);
        send_frame(f);
        if (i == PhaseItems / 2) drain_results();
      end
    end

    frame_ch.valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d frames, checked %0d result words", board.n_frames, board.n_results);
    $display("seen %0d sector one/two splits, %0d closed last sectors, %0d best lap reports",
             board.n_split, board.n_final, board.n_best);
    if (board.errors == 0) begin
      $display("PASS lap_sector_split_timer");
    end else begin
      $display("FAIL lap_sector_split_timer");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lst_pkg.sv
rtl/lst_frame_if.sv
rtl/lst_result_if.sv
rtl/lap_sector_split_timer.sv
tb/lap_sector_split_timer_tb.sv
